// ===== sv/pcn_pkg.sv =====
// Shared types and constants of the point cloud normalizer.
`timescale 1ns / 1ps
package pcn_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int COORD_W        = 16;
   localparam int SUM_W          = 22;
   localparam int CEN_W          = 17;
   localparam int SQ_W           = 34;
   localparam int DIST_W         = 18;
   localparam int DIV_N_W        = 33;
   localparam int DIV_D_W        = 19;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_SCAN_RD,
      ST_SCAN_C,
      ST_SCAN_SQ,
      ST_SCAN_MAX,
      ST_SQRT,
      ST_EMIT_RD,
      ST_EMIT_C,
      ST_EMIT_GO,
      ST_EMIT_WAIT,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== sv/pcn_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pcn_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/pcn_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcn_div import pcn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic [DIV_N_W-1:0] quotient,
   output div_status_type     status
);

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   rem_sh;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, quo_ff[DIV_N_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_N_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DIV_D_W'(rem_sh - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DIV_D_W-1:0];
            quo_in = {quo_ff[DIV_N_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sv/point_cloud_normalizer.sv =====
// Point cloud normalizer: loads a cloud, centers it and scales it to the unit sphere.
// Usage: send points on the req_ channel, one word per cycle, req_is_last on the
// final point. Up to MAX_POINTS points are kept in a RAM; extra points are dropped
// and every result of that cloud carries rsp_points_dropped.
// After the last point req_stall stays high while the cloud is processed:
//   centroid: three divisions, one per axis, in the shared bit-serial divider,
//   distance scan per point: RAM read, center, three squares, max,
//   square root: one result bit per cycle,
//   emission per point: RAM read, center, three divisions, then the load of the
//   output register (the divisions are skipped when the scale is zero).
// Results come out on rsp_ in load order, rsp_end_of_cloud on the last one;
// then req_stall drops and the next cloud may load. Points load back to back.
// A stalled result holds in the output register and the emission sequencer
// waits for it; during load the register may still hold the last word.
// Synchronous reset empties the cloud and the output register; no RAM clearing.
`timescale 1ns / 1ps
module point_cloud_normalizer import pcn_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_point_x,
   input  logic signed [COORD_W-1:0]  req_point_y,
   input  logic signed [COORD_W-1:0]  req_point_z,
   input  logic                       req_is_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_W-1:0]  rsp_norm_x,
   output logic signed [COORD_W-1:0]  rsp_norm_y,
   output logic signed [COORD_W-1:0]  rsp_norm_z,
   output logic                       rsp_end_of_cloud,
   output logic                       rsp_points_dropped
);

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int PT_W   = 3 * COORD_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [CEN_W-1:0]  mean_ff [3];
   logic signed [CEN_W-1:0]  mean_in [3];
   logic signed [CEN_W-1:0]  c_ff [3];
   logic signed [CEN_W-1:0]  c_in [3];
   logic signed [COORD_W-1:0] nrm_ff [3];
   logic signed [COORD_W-1:0] nrm_in [3];
   logic [1:0]               ax_ff, ax_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [SQ_W-1:0]          acc_ff, acc_in;
   logic [SQ_W-1:0]          best_ff, best_in;
   logic [SQ_W-1:0]          sqv_ff, sqv_in;
   logic [SQ_W-1:0]          sqr_ff, sqr_in;
   logic [SQ_W-1:0]          sqb_ff, sqb_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                     rsp_end_ff, rsp_end_in, rsp_drop_ff, rsp_drop_in;

   logic                     req_acc;
   logic                     store_ok;
   logic                     last_idx;
   logic                     out_free;
   logic [PT_W-1:0]          rd_data;
   logic                     div_start;
   logic [DIV_N_W-1:0]       div_dividend;
   logic [DIV_D_W-1:0]       div_divisor;
   logic [DIV_N_W-1:0]       div_quo;
   div_status_type           div_st;

   logic signed [SUM_W:0]    sum_sel;
   logic [SUM_W:0]           sum_mag;
   logic [CEN_W-1:0]         c_mag;
   logic signed [SQ_W-1:0]   prod;
   logic [SQ_W-1:0]          acc_next;
   logic [SQ_W-1:0]          best_next;
   logic [SQ_W-1:0]          sq_try;
   logic [SQ_W-1:0]          sqr_next;
   logic [COORD_W-1:0]       q_sat;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_LOAD);
   assign store_ok  = (count_ff < CNT_W'(MAX_POINTS));
   assign last_idx  = (CNT_W'(idx_ff) == count_ff - 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   pcn_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (req_acc && store_ok),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_point_z, req_point_y, req_point_x}),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // shared divider: rounded quotient = (2|num| + den) / (2 den)
   always_comb begin
      sum_sel = {sum_ff[ax_ff][SUM_W-1], sum_ff[ax_ff]};
      sum_mag = sum_sel[SUM_W] ? unsigned'(-sum_sel) : unsigned'(sum_sel);
      c_mag   = c_ff[ax_ff][CEN_W-1] ? unsigned'(-c_ff[ax_ff]) : unsigned'(c_ff[ax_ff]);
      if (state_ff == ST_MEAN_GO) begin
         div_start    = 1'b1;
         div_dividend = DIV_N_W'({sum_mag, 1'b0}) + DIV_N_W'(count_ff);
         div_divisor  = DIV_D_W'({count_ff, 1'b0});
      end else begin
         div_start    = (state_ff == ST_EMIT_GO) && (dist_ff != '0);
         div_dividend = {c_mag, 16'b0} + DIV_N_W'(dist_ff);
         div_divisor  = {dist_ff, 1'b0};
      end
   end

   pcn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_st)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (req_acc && req_is_last) state_in = ST_MEAN_GO;
         ST_MEAN_GO:   state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: if (div_st.done) state_in = (ax_ff == 2'd2) ? ST_SCAN_RD : ST_MEAN_GO;
         ST_SCAN_RD:   state_in = ST_SCAN_C;
         ST_SCAN_C:    state_in = ST_SCAN_SQ;
         ST_SCAN_SQ:   if (ax_ff == 2'd2) state_in = ST_SCAN_MAX;
         ST_SCAN_MAX:  state_in = last_idx ? ST_SQRT : ST_SCAN_RD;
         ST_SQRT:      if (sqb_ff == SQ_W'(1)) state_in = ST_EMIT_RD;
         ST_EMIT_RD:   state_in = ST_EMIT_C;
         ST_EMIT_C:    state_in = ST_EMIT_GO;
         ST_EMIT_GO: begin
            if (dist_ff != '0) state_in = ST_EMIT_WAIT;
            else if (ax_ff == 2'd2) state_in = ST_EMIT_OUT;
         end
         ST_EMIT_WAIT: if (div_st.done) state_in = (ax_ff == 2'd2) ? ST_EMIT_OUT : ST_EMIT_GO;
         ST_EMIT_OUT:  if (out_free) state_in = last_idx ? ST_LOAD : ST_EMIT_RD;
         default:      state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      c_in         = c_ff;
      nrm_in       = nrm_ff;
      ax_in        = ax_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      sqv_in       = sqv_ff;
      sqr_in       = sqr_ff;
      sqb_in       = sqb_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_drop_in  = rsp_drop_ff;

      prod      = c_ff[ax_ff] * c_ff[ax_ff];
      acc_next  = acc_ff + unsigned'(prod);
      best_next = (acc_ff > best_ff) ? acc_ff : best_ff;
      sq_try    = sqr_ff + sqb_ff;
      sqr_next  = sqr_ff >> 1;

      // saturate the rounded magnitude and apply the sign
      if (c_ff[ax_ff][CEN_W-1]) begin
         q_sat = (div_quo >= DIV_N_W'(32768)) ? 16'h8000 : 16'(-div_quo[15:0]);
      end else begin
         q_sat = (div_quo >= DIV_N_W'(32768)) ? 16'h7fff : div_quo[15:0];
      end

      case (state_ff)
         ST_LOAD: begin
            ax_in = 2'd0;
            if (req_acc) begin
               if (store_ok) begin
                  count_in  = count_ff + 1'b1;
                  sum_in[0] = sum_ff[0] + SUM_W'(req_point_x);
                  sum_in[1] = sum_ff[1] + SUM_W'(req_point_y);
                  sum_in[2] = sum_ff[2] + SUM_W'(req_point_z);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_MEAN_WAIT: begin
            if (div_st.done) begin
               mean_in[ax_ff] = sum_ff[ax_ff][SUM_W-1] ? -CEN_W'(div_quo[CEN_W-1:0])
                                                      : CEN_W'(div_quo[CEN_W-1:0]);
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_SCAN_C, ST_EMIT_C: begin
            for (int a = 0; a < 3; a++) begin
               c_in[a] = CEN_W'(signed'(rd_data[a*COORD_W +: COORD_W])) - mean_ff[a];
            end
            ax_in  = 2'd0;
            acc_in = '0;
         end
         ST_SCAN_SQ: begin
            acc_in = acc_next;
            ax_in  = ax_ff + 1'b1;
         end
         ST_SCAN_MAX: begin
            best_in = best_next;
            if (last_idx) begin
               idx_in = '0;
               sqv_in = best_next;
               sqr_in = '0;
               sqb_in = SQ_W'(1) << 32;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SQRT: begin
            if (sqv_ff >= sq_try) begin
               sqv_in = sqv_ff - sq_try;
               sqr_in = sqr_next + sqb_ff;
            end else begin
               sqr_in = sqr_next;
            end
            sqb_in = sqb_ff >> 2;
            if (sqb_ff == SQ_W'(1)) dist_in = sqr_in[DIST_W-1:0];
         end
         ST_EMIT_GO: begin
            if (dist_ff == '0) begin
               nrm_in[ax_ff] = '0;
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_EMIT_WAIT: begin
            if (div_st.done) begin
               nrm_in[ax_ff] = q_sat;
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = nrm_ff[0];
               rsp_y_in     = nrm_ff[1];
               rsp_z_in     = nrm_ff[2];
               rsp_end_in   = last_idx;
               rsp_drop_in  = ovf_ff;
               if (last_idx) begin
                  idx_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sum_in   = '{default: '0};
                  best_in  = '0;
                  dist_in  = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '{default: '0};
         ax_ff        <= '0;
         idx_ff       <= '0;
         best_ff      <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         ax_ff        <= ax_in;
         idx_ff       <= idx_in;
         best_ff      <= best_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff     <= mean_in;
      c_ff        <= c_in;
      nrm_ff      <= nrm_in;
      acc_ff      <= acc_in;
      sqv_ff      <= sqv_in;
      sqr_ff      <= sqr_in;
      sqb_ff      <= sqb_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_norm_x         = rsp_x_ff;
   assign rsp_norm_y         = rsp_y_ff;
   assign rsp_norm_z         = rsp_z_ff;
   assign rsp_end_of_cloud   = rsp_end_ff;
   assign rsp_points_dropped = rsp_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT_OUT))
      else $error("result word loaded outside emission");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (count_ff != '0))
      else $error("processing an empty cloud");

endmodule

// ===== tb/point_cloud_normalizer_tb.sv =====
// Testbench for the point cloud normalizer: directed and random clouds checked against a built-in predictor.
`timescale 1ns / 1ps
module point_cloud_normalizer_tb import pcn_pkg::*;;

   localparam int  CAP         = MAX_POINTS_DEF;
   localparam int  TIMEOUT_CYC = 1500000;
   localparam int  HOLD_CYC    = 3000;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      eoc;
      logic                      dropped;
   } norm_word_type;

   // Rounded division, ties away from zero; den > 0.
   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint floor_sqrt(longint v);
      longint res;
      longint bitv;
      res  = 0;
      bitv = 64'd1 << 36;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   class cloud_scoreboard;
      longint        pts [CAP][3];
      int            n_stored;
      longint        sums [3];
      bit            overflow;
      norm_word_type due [$];
      int            mismatches;
      int            words_checked;
      int            clouds_done;

      function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                               logic signed [COORD_W-1:0] z, logic last);
         longint        mean [3];
         longint        best;
         longint        sq;
         longint        c;
         longint        q;
         longint        scale;
         norm_word_type w;
         if (n_stored < CAP) begin
            pts[n_stored][0] = x;
            pts[n_stored][1] = y;
            pts[n_stored][2] = z;
            sums[0] += x;
            sums[1] += y;
            sums[2] += z;
            n_stored++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         if (n_stored != 0) begin
            for (int a = 0; a < 3; a++) mean[a] = round_div(sums[a], n_stored);
            best = 0;
            for (int i = 0; i < n_stored; i++) begin
               sq = 0;
               for (int a = 0; a < 3; a++) begin
                  c  = pts[i][a] - mean[a];
                  sq += c * c;
               end
               if (sq > best) best = sq;
            end
            scale = floor_sqrt(best);
            for (int i = 0; i < n_stored; i++) begin
               for (int a = 0; a < 3; a++) begin
                  c = pts[i][a] - mean[a];
                  q = 0;
                  if (scale != 0) begin
                     q = round_div(c * 32768, scale);
                     if (q > 32767) q = 32767;
                     if (q < -32768) q = -32768;
                  end
                  if (a == 0) w.x = q[15:0];
                  else if (a == 1) w.y = q[15:0];
                  else w.z = q[15:0];
               end
               w.eoc     = (i + 1 == n_stored);
               w.dropped = overflow;
               due       = {due, w};
            end
            clouds_done++;
         end
         n_stored = 0;
         sums     = '{0, 0, 0};
         overflow = 0;
      endfunction

      function void check_result(norm_word_type got);
         norm_word_type exp_w;
         words_checked++;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: x=%0d y=%0d z=%0d eoc=%0b drop=%0b",
                        got.x, got.y, got.z, got.eoc, got.dropped);
            return;
         end
         exp_w = due.pop_front();
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp x=%0d y=%0d z=%0d eoc=%0b drop=%0b,",
                         " got x=%0d y=%0d z=%0d eoc=%0b drop=%0b"},
                        exp_w.x, exp_w.y, exp_w.z, exp_w.eoc, exp_w.dropped,
                        got.x, got.y, got.z, got.eoc, got.dropped);
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_point_x;
   logic signed [COORD_W-1:0] req_point_y;
   logic signed [COORD_W-1:0] req_point_z;
   logic                      req_is_last;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [COORD_W-1:0] rsp_norm_x;
   logic signed [COORD_W-1:0] rsp_norm_y;
   logic signed [COORD_W-1:0] rsp_norm_z;
   logic                      rsp_end_of_cloud;
   logic                      rsp_points_dropped;

   cloud_scoreboard sb = new();
   int  cycle_count = 0;
   int  hold_asks   = 0;
   int  points_sent;

   point_cloud_normalizer dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // monitors sample pre-edge values
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_point(req_point_x, req_point_y, req_point_z, req_is_last);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_norm_x, rsp_norm_y, rsp_norm_z,
                          rsp_end_of_cloud, rsp_points_dropped});
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYC) begin
         $display("timeout with %0d words outstanding", sb.due.size());
         $display("[point_cloud_normalizer] ERROR");
         $finish;
      end
   end

   // receiver: calm stretches, random stalls, and an occasional long hold
   initial begin : receiver
      int phase_left;
      int stall_pct;
      int holds_served;
      rsp_stall    = 0;
      phase_left   = 0;
      stall_pct    = 0;
      holds_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks > holds_served) begin
            holds_served++;
            rsp_stall <= 1;
            repeat (HOLD_CYC) @(posedge clock);
            rsp_stall <= 0;
         end else begin
            if (phase_left == 0) begin
               phase_left = $urandom_range(20, 300);
               stall_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            phase_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z, logic last);
      req_valid   <= 1;
      req_point_x <= x;
      req_point_y <= y;
      req_point_z <= z;
      req_is_last <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      points_sent++;
      // random gap after this word, or keep the burst going
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending until every expected word has been checked
   task automatic drain();
      req_valid <= 0;
      @(negedge clock);
      wait (sb.due.size() == 0);
      @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord(int spread);
      case (spread)
         0: return 16'($urandom_range(0, 65535));
         1: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
         2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
      endcase
   endfunction

   task automatic send_cloud(int npts, int spread);
      for (int i = 0; i < npts; i++)
         send_point(rand_coord(spread), rand_coord(spread), rand_coord(spread), i == npts - 1);
   endtask

   initial begin : stimulus
      int sz;
      reset        = 1;
      req_valid    = 0;
      req_point_x  = 0;
      req_point_y  = 0;
      req_point_z  = 0;
      req_is_last  = 0;
      points_sent  = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single point: zero scale
      send_point(16'sh7fff, 16'sh8000, 16'sd0, 1'b1);
      // two points at opposite extremes
      send_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      // identical points: zero scale
      repeat (3) send_point(16'sd1234, -16'sd77, 16'sd5, 1'b0);
      send_point(16'sd1234, -16'sd77, 16'sd5, 1'b1);
      // axis extremes, ties in rounding
      send_point(16'sh7fff, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sh8000, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sh7fff, 1'b0);
      send_point(-16'sd1, 16'sd1, -16'sd1, 1'b1);
      send_point(16'sd3, 16'sd0, 16'sd0, 1'b0);
      send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_cloud(6, 2);
      send_cloud(4, 0);

      drain();

      // random clouds; a long receiver hold and one full sender pause
      for (int k = 0; k < 6; k++) begin
         sz = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
         if (k == 1) hold_asks++;
         send_cloud(sz, $urandom_range(0, 3));
         if (k == 4) drain();
      end
      // fills the store and drops the extra points
      send_cloud(CAP + 3, $urandom_range(0, 3));
      send_cloud($urandom_range(1, 5), 0);

      drain();
      repeat (400) @(posedge clock);
      $display("sent %0d points in %0d clouds, checked %0d normalized words",
               points_sent, sb.clouds_done, sb.words_checked);
      $display("covered zero scale, extremes, a full store and an overflowing cloud");
      if (sb.mismatches == 0 && sb.due.size() == 0)
         $display("[point_cloud_normalizer] OK");
      else
         $display("[point_cloud_normalizer] ERROR");
      $finish;
   end
endmodule
